// ===== sv/scdp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdp_pkg
// Shared constants, types and field tables for the SNAP/CDP record parser.
// ----------------------------------------------------------------------------
package scdp_pkg;

	// captured field sizes in bytes
	localparam int DEVICE_ID_BYTES = 16;
	localparam int PORT_BYTES      = 10;
	localparam int VERSION_BYTES   = 6;
	localparam int PLATFORM_BYTES  = 16;

	localparam int STORE_BYTES = DEVICE_ID_BYTES + PORT_BYTES + VERSION_BYTES + PLATFORM_BYTES;
	localparam int STORE_AW    = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

	localparam int MAX_A = (DEVICE_ID_BYTES > PORT_BYTES) ? DEVICE_ID_BYTES : PORT_BYTES;
	localparam int MAX_B = (VERSION_BYTES > PLATFORM_BYTES) ? VERSION_BYTES : PLATFORM_BYTES;
	localparam int MAX_FLD_BYTES = (MAX_A > MAX_B) ? MAX_A : MAX_B;
	localparam int IDX_W = (MAX_FLD_BYTES > 1) ? $clog2(MAX_FLD_BYTES) : 1;
	localparam int SZ_W  = $clog2(MAX_FLD_BYTES + 1);

	// field ids
	localparam logic [1:0] FLD_DEVICE   = 2'd0;
	localparam logic [1:0] FLD_PORT     = 2'd1;
	localparam logic [1:0] FLD_VERSION  = 2'd2;
	localparam logic [1:0] FLD_PLATFORM = 2'd3;

	// frame classes
	localparam logic [2:0] CLS_CDP         = 3'd0;
	localparam logic [2:0] CLS_WLCCP       = 3'd1;
	localparam logic [2:0] CLS_UNK_SNAP    = 3'd2;
	localparam logic [2:0] CLS_UNK_VERSION = 3'd3;
	localparam logic [2:0] CLS_SHORT       = 3'd4;

	// result kinds
	localparam logic KIND_CLASS  = 1'b0;
	localparam logic KIND_STRING = 1'b1;

	// protocol constants
	localparam logic [15:0] SNAP_DISC  = 16'h2000;
	localparam logic [15:0] SNAP_ZERO  = 16'h0000;
	localparam logic [7:0]  CDP_V1     = 8'h01;
	localparam logic [15:0] TLV_DEVICE   = 16'h0001;
	localparam logic [15:0] TLV_PORT     = 16'h0003;
	localparam logic [15:0] TLV_VERSION  = 16'h0005;
	localparam logic [15:0] TLV_PLATFORM = 16'h0006;

	// byte positions within the frame
	localparam logic [15:0] POS_SNAP_HI = 16'd6;
	localparam logic [15:0] POS_SNAP_LO = 16'd7;
	localparam logic [15:0] POS_VERSION = 16'd8;
	localparam logic [15:0] POS_TLV     = 16'd12;
	localparam logic [15:0] TLV_HDR     = 16'd4;

	typedef struct packed {
		logic       hit;
		logic [1:0] id;
	} scdp_fld_t;

	// controller to datapath
	typedef struct packed {
		logic take;      // accept the input byte
		logic cls_load;  // load class result into the output register
		logic rd_start;  // first store read of the dump
		logic rd_next;   // advance dump position and read
		logic str_load;  // load string byte into the output register
		logic clear;     // return frame state to zero
	} scdp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic is_cdp;
		logic dump_last;
	} scdp_sts_t;

	function automatic scdp_fld_t field_of(logic [15:0] t);
		scdp_fld_t r;
		r = '0;
		case (t)
			TLV_DEVICE: begin
				r.hit = 1'b1;
				r.id = FLD_DEVICE;
			end
			TLV_PORT: begin
				r.hit = 1'b1;
				r.id = FLD_PORT;
			end
			TLV_VERSION: begin
				r.hit = 1'b1;
				r.id = FLD_VERSION;
			end
			TLV_PLATFORM: begin
				r.hit = 1'b1;
				r.id = FLD_PLATFORM;
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [SZ_W-1:0] fld_size(logic [1:0] f);
		logic [SZ_W-1:0] r;
		case (f)
			FLD_DEVICE:  r = SZ_W'(DEVICE_ID_BYTES);
			FLD_PORT:    r = SZ_W'(PORT_BYTES);
			FLD_VERSION: r = SZ_W'(VERSION_BYTES);
			default:     r = SZ_W'(PLATFORM_BYTES);
		endcase
		return r;
	endfunction

	function automatic logic [STORE_AW-1:0] fld_base(logic [1:0] f);
		logic [STORE_AW-1:0] r;
		case (f)
			FLD_DEVICE:  r = '0;
			FLD_PORT:    r = STORE_AW'(DEVICE_ID_BYTES);
			FLD_VERSION: r = STORE_AW'(DEVICE_ID_BYTES + PORT_BYTES);
			default:     r = STORE_AW'(DEVICE_ID_BYTES + PORT_BYTES + VERSION_BYTES);
		endcase
		return r;
	endfunction

endpackage

// ===== sv/scdp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdp_ctrl
// Sequencer: receive bytes, emit class result, then, for CDP frames, dump the string store.
// ----------------------------------------------------------------------------
module scdp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                frame_last,
	output logic                in_ready,
	input  scdp_pkg::scdp_sts_t sts,
	output scdp_pkg::scdp_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_RUN,
		S_CLASS,
		S_DUMP
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_RUN: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			S_CLASS: begin
				if (sts.out_free) begin
					cmd.cls_load = 1'b1;
					cmd.rd_start = sts.is_cdp;
					cmd.clear = !sts.is_cdp;
				end
			end
			S_DUMP: begin
				if (sts.out_free) begin
					cmd.str_load = 1'b1;
					cmd.clear = sts.dump_last;
					cmd.rd_next = !sts.dump_last;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
		end else begin
			case (state_q)
				S_RUN: begin
					if (in_valid && frame_last)
						state_q <= S_CLASS;
				end
				S_CLASS: begin
					if (sts.out_free)
						state_q <= sts.is_cdp ? S_DUMP : S_RUN;
				end
				S_DUMP: begin
					if (sts.out_free && sts.dump_last)
						state_q <= S_RUN;
				end
				default: state_q <= S_RUN;
			endcase
		end
	end

endmodule

// ===== sv/scdp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdp_dp
// Frame registers, record walker, string store and output register.
// ----------------------------------------------------------------------------
module scdp_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  scdp_pkg::scdp_cmd_t cmd,
	output scdp_pkg::scdp_sts_t sts,
	input  logic [7:0]          data_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                item_kind,
	output logic [2:0]          frame_class,
	output logic [15:0]         type_code,
	output logic [1:0]          field_id,
	output logic [3:0]          byte_index,
	output logic [7:0]          byte_value,
	output logic                run_last
);

	localparam logic [15:0] OFS_TYPE_HI = 16'd0;
	localparam logic [15:0] OFS_TYPE_LO = 16'd1;
	localparam logic [15:0] OFS_LEN_HI  = 16'd2;
	localparam logic [15:0] OFS_LEN_LO  = 16'd3;

	logic [15:0] frame_pos_q;
	logic [15:0] snap_type_q;
	logic [7:0]  version_q;
	logic [15:0] rec_type_q;
	logic [15:0] rec_length_q;
	logic [15:0] rec_offset_q;
	logic        stopped_q;
	logic [scdp_pkg::STORE_BYTES-1:0] valid_q;

	logic [7:0] mem_q [scdp_pkg::STORE_BYTES];
	logic [7:0] rd_q;
	logic       rv_q;

	logic [1:0]                 dfield_q;
	logic [scdp_pkg::IDX_W-1:0] didx_q;

	logic        out_valid_q;
	logic        kind_q;
	logic [2:0]  class_q;
	logic [15:0] code_q;
	logic [1:0]  fid_q;
	logic [3:0]  bidx_q;
	logic [7:0]  bval_q;
	logic        last_q;

	// record walker
	logic                         walk;
	scdp_pkg::scdp_fld_t          fo;
	logic [15:0]                  len_full;
	logic [15:0]                  off_m4;
	logic [15:0]                  ofs_inc;
	logic [15:0]                  len_eff;
	logic                         short_len;
	logic                         wr_en;
	logic [scdp_pkg::STORE_AW-1:0] wa;
	logic                         fld_clr;
	logic [scdp_pkg::STORE_AW-1:0] clr_base;
	logic [scdp_pkg::STORE_AW:0]   clr_end;

	// class
	logic [2:0]  cls;
	logic [15:0] code;

	// dump
	logic                          cur_last;
	logic [1:0]                    nfield;
	logic [scdp_pkg::IDX_W-1:0]    nidx;
	logic [scdp_pkg::STORE_AW-1:0] ra;
	logic                          rd_en;

	always_comb begin
		walk = cmd.take && (frame_pos_q >= scdp_pkg::POS_TLV)
			&& (snap_type_q == scdp_pkg::SNAP_DISC) && (version_q == scdp_pkg::CDP_V1)
			&& !stopped_q;
		fo = scdp_pkg::field_of(rec_type_q);
		len_full = {rec_length_q[15:8], data_byte};
		short_len = (len_full < scdp_pkg::TLV_HDR);
		off_m4 = rec_offset_q - scdp_pkg::TLV_HDR;
		ofs_inc = rec_offset_q + 16'd1;
		len_eff = (rec_offset_q == OFS_LEN_LO) ? len_full : rec_length_q;
		wr_en = walk && (rec_offset_q >= scdp_pkg::TLV_HDR) && fo.hit
			&& (off_m4 < 16'(scdp_pkg::fld_size(fo.id)));
		wa = scdp_pkg::fld_base(fo.id) + scdp_pkg::STORE_AW'(off_m4);
		fld_clr = walk && (rec_offset_q == OFS_LEN_LO) && !short_len && fo.hit;
		clr_base = scdp_pkg::fld_base(fo.id);
		clr_end = {1'b0, clr_base} + (scdp_pkg::STORE_AW + 1)'(scdp_pkg::fld_size(fo.id));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos_q <= '0;
			snap_type_q <= '0;
			version_q <= '0;
			rec_type_q <= '0;
			rec_length_q <= '0;
			rec_offset_q <= '0;
			stopped_q <= 1'b0;
			valid_q <= '0;
		end else if (cmd.clear) begin
			frame_pos_q <= '0;
			snap_type_q <= '0;
			version_q <= '0;
			rec_type_q <= '0;
			rec_length_q <= '0;
			rec_offset_q <= '0;
			stopped_q <= 1'b0;
			valid_q <= '0;
		end else if (cmd.take) begin
			if (frame_pos_q != 16'hffff)
				frame_pos_q <= frame_pos_q + 16'd1;
			if (frame_pos_q == scdp_pkg::POS_SNAP_HI) begin
				snap_type_q[15:8] <= data_byte;
			end else if (frame_pos_q == scdp_pkg::POS_SNAP_LO) begin
				snap_type_q[7:0] <= data_byte;
			end else if (frame_pos_q == scdp_pkg::POS_VERSION) begin
				version_q <= data_byte;
			end else if (walk) begin
				case (rec_offset_q)
					OFS_TYPE_HI: rec_type_q <= {data_byte, 8'h00};
					OFS_TYPE_LO: rec_type_q[7:0] <= data_byte;
					OFS_LEN_HI:  rec_length_q <= {data_byte, 8'h00};
					OFS_LEN_LO:  rec_length_q[7:0] <= data_byte;
					default:     rec_length_q <= rec_length_q;
				endcase
				// a record length under the header size ends the walk
				if (rec_offset_q == OFS_LEN_LO && short_len)
					stopped_q <= 1'b1;
				else if (ofs_inc >= scdp_pkg::TLV_HDR && ofs_inc >= len_eff)
					rec_offset_q <= '0;
				else
					rec_offset_q <= ofs_inc;
				for (int e = 0; e < scdp_pkg::STORE_BYTES; e++) begin
					if (fld_clr && (e >= int'(clr_base)) && (e < int'(clr_end)))
						valid_q[e] <= 1'b0;
				end
				if (wr_en)
					valid_q[wa] <= 1'b1;
			end
		end
	end

	// class of the finished frame; frame_pos is already one past the last byte
	always_comb begin
		code = '0;
		if (frame_pos_q <= scdp_pkg::POS_SNAP_LO) begin
			cls = scdp_pkg::CLS_SHORT;
		end else if (snap_type_q == scdp_pkg::SNAP_DISC) begin
			if (frame_pos_q <= scdp_pkg::POS_VERSION) begin
				cls = scdp_pkg::CLS_SHORT;
			end else if (version_q != scdp_pkg::CDP_V1) begin
				cls = scdp_pkg::CLS_UNK_VERSION;
				code = {8'h00, version_q};
			end else begin
				cls = scdp_pkg::CLS_CDP;
			end
		end else if (snap_type_q == scdp_pkg::SNAP_ZERO) begin
			cls = scdp_pkg::CLS_WLCCP;
		end else begin
			cls = scdp_pkg::CLS_UNK_SNAP;
			code = snap_type_q;
		end
	end

	// dump walk over fields and byte positions
	always_comb begin
		cur_last = (didx_q == scdp_pkg::IDX_W'(scdp_pkg::fld_size(dfield_q) - scdp_pkg::SZ_W'(1)));
		if (cmd.rd_start) begin
			nfield = scdp_pkg::FLD_DEVICE;
			nidx = '0;
		end else if (cur_last) begin
			nfield = dfield_q + 2'd1;
			nidx = '0;
		end else begin
			nfield = dfield_q;
			nidx = didx_q + scdp_pkg::IDX_W'(1);
		end
		ra = scdp_pkg::fld_base(nfield) + scdp_pkg::STORE_AW'(nidx);
		rd_en = cmd.rd_start || cmd.rd_next;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wa] <= data_byte;
		if (rd_en) begin
			rd_q <= mem_q[ra];
			rv_q <= valid_q[ra];
			dfield_q <= nfield;
			didx_q <= nidx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.cls_load || cmd.str_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.cls_load) begin
			kind_q <= scdp_pkg::KIND_CLASS;
			class_q <= cls;
			code_q <= code;
			fid_q <= '0;
			bidx_q <= '0;
			bval_q <= '0;
			last_q <= (cls != scdp_pkg::CLS_CDP);
		end else if (cmd.str_load) begin
			kind_q <= scdp_pkg::KIND_STRING;
			class_q <= '0;
			code_q <= '0;
			fid_q <= dfield_q;
			bidx_q <= 4'(didx_q);
			bval_q <= rv_q ? rd_q : 8'h00;
			last_q <= (dfield_q == scdp_pkg::FLD_PLATFORM) && cur_last;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.is_cdp = (cls == scdp_pkg::CLS_CDP);
	assign sts.dump_last = (dfield_q == scdp_pkg::FLD_PLATFORM) && cur_last;

	assign out_valid = out_valid_q;
	assign item_kind = kind_q;
	assign frame_class = class_q;
	assign type_code = code_q;
	assign field_id = fid_q;
	assign byte_index = bidx_q;
	assign byte_value = bval_q;
	assign run_last = last_q;

endmodule

// ===== sv/snap_cdp_tlv_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snap_cdp_tlv_parser
// LLC/SNAP frame classifier with a CDP v1 record walker and string capture.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per cycle while in_ready is high. After the last
// byte the block stops taking input, forms the class, then sends the class
// result and, for CDP version 1 frames, the 48 captured string bytes (device
// id, port, version, platform) at one per cycle when the output does not
// stall, from the single read port of the string store. Input is thus held
// off until the frame's last result is loaded, longer if the output stalls.
// A finished result waits in an output register while the next frame's bytes
// are accepted.
module snap_cdp_tlv_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        frame_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        item_kind,
	output logic [2:0]  frame_class,
	output logic [15:0] type_code,
	output logic [1:0]  field_id,
	output logic [3:0]  byte_index,
	output logic [7:0]  byte_value,
	output logic        run_last
);

	scdp_pkg::scdp_cmd_t cmd;
	scdp_pkg::scdp_sts_t sts;

	scdp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.frame_last (frame_last),
		.in_ready   (in_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	scdp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.item_kind   (item_kind),
		.frame_class (frame_class),
		.type_code   (type_code),
		.field_id    (field_id),
		.byte_index  (byte_index),
		.byte_value  (byte_value),
		.run_last    (run_last)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for snap_cdp_tlv_parser. Frames go in one byte per
// request; a tracker of the SNAP class and the CDP record walk predicts the
// class result and the captured string bytes, and a monitor compares each
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct packed {
		logic        kind;
		logic [2:0]  cls;
		logic [15:0] code;
		logic [1:0]  fld;
		logic [3:0]  idx;
		logic [7:0]  val;
		logic        is_last;
	} parse_res_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        frame_last;
	logic        out_valid;
	logic        out_ready;
	logic        item_kind;
	logic [2:0]  frame_class;
	logic [15:0] type_code;
	logic [1:0]  field_id;
	logic [3:0]  byte_index;
	logic [7:0]  byte_value;
	logic        run_last;

	snap_cdp_tlv_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.frame_last(frame_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_kind(item_kind),
		.frame_class(frame_class),
		.type_code(type_code),
		.field_id(field_id),
		.byte_index(byte_index),
		.byte_value(byte_value),
		.run_last(run_last)
	);

	// frame tracker
	logic [15:0] trk_pos;
	logic [15:0] trk_snap;
	logic [7:0]  trk_ver;
	logic [15:0] trk_rtype;
	logic [15:0] trk_rlen;
	int          trk_roff;
	bit          trk_stopped;
	logic [7:0]  trk_store [scdp_pkg::STORE_BYTES];
	int fsize [4] = '{scdp_pkg::DEVICE_ID_BYTES, scdp_pkg::PORT_BYTES,
		scdp_pkg::VERSION_BYTES, scdp_pkg::PLATFORM_BYTES};
	int fbase [4] = '{0, scdp_pkg::DEVICE_ID_BYTES,
		scdp_pkg::DEVICE_ID_BYTES + scdp_pkg::PORT_BYTES,
		scdp_pkg::DEVICE_ID_BYTES + scdp_pkg::PORT_BYTES + scdp_pkg::VERSION_BYTES};

	parse_res_t  due_results[$];
	logic [7:0]  fbytes[$];
	int          err_count = 0;
	bit          gaps_on;
	bit          stalls_on;
	int          sink_hold;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("tb_top: errors");
		$finish;
	end

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		err_count++;
		if (err_count <= 30)
			$display("%0t mismatch on %s: got %h want %h", $time, what, got, want);
	endtask

	function automatic int tlv_slot(logic [15:0] t);
		case (t)
			scdp_pkg::TLV_DEVICE:   return int'(scdp_pkg::FLD_DEVICE);
			scdp_pkg::TLV_PORT:     return int'(scdp_pkg::FLD_PORT);
			scdp_pkg::TLV_VERSION:  return int'(scdp_pkg::FLD_VERSION);
			scdp_pkg::TLV_PLATFORM: return int'(scdp_pkg::FLD_PLATFORM);
			default:                return -1;
		endcase
	endfunction

	function automatic void clear_tracker();
		trk_pos = '0;
		trk_snap = '0;
		trk_ver = '0;
		trk_rtype = '0;
		trk_rlen = '0;
		trk_roff = 0;
		trk_stopped = 1'b0;
		foreach (trk_store[i])
			trk_store[i] = 8'h00;
	endfunction

	function automatic void track_frame_byte(logic [7:0] b, logic l);
		logic [15:0] pos;
		int          f;
		logic [2:0]  cls;
		logic [15:0] code;
		parse_res_t  r;
		pos = trk_pos;
		if (pos == scdp_pkg::POS_SNAP_HI)
			trk_snap[15:8] = b;
		else if (pos == scdp_pkg::POS_SNAP_LO)
			trk_snap[7:0] = b;
		else if (pos == scdp_pkg::POS_VERSION)
			trk_ver = b;
		else if (pos >= scdp_pkg::POS_TLV && trk_snap == scdp_pkg::SNAP_DISC
				&& trk_ver == scdp_pkg::CDP_V1 && !trk_stopped) begin
			f = tlv_slot(trk_rtype);
			case (trk_roff)
				0: trk_rtype = {b, 8'h00};
				1: trk_rtype[7:0] = b;
				2: trk_rlen = {b, 8'h00};
				3: begin
					trk_rlen[7:0] = b;
					if (trk_rlen < scdp_pkg::TLV_HDR)
						trk_stopped = 1'b1;
					else if (f >= 0)
						for (int i = 0; i < fsize[f]; i++)
							trk_store[fbase[f] + i] = 8'h00;
				end
				default: begin
					// value bytes beyond the field size are dropped
					if (f >= 0 && trk_roff - 4 < fsize[f])
						trk_store[fbase[f] + trk_roff - 4] = b;
				end
			endcase
			if (!trk_stopped) begin
				trk_roff++;
				if (trk_roff >= scdp_pkg::TLV_HDR && trk_roff >= trk_rlen)
					trk_roff = 0;
			end
		end
		if (trk_pos != 16'hffff)
			trk_pos++;
		if (!l)
			return;

		code = '0;
		if (pos < scdp_pkg::POS_SNAP_LO)
			cls = scdp_pkg::CLS_SHORT;
		else if (trk_snap == scdp_pkg::SNAP_DISC) begin
			if (pos < scdp_pkg::POS_VERSION)
				cls = scdp_pkg::CLS_SHORT;
			else if (trk_ver != scdp_pkg::CDP_V1) begin
				cls = scdp_pkg::CLS_UNK_VERSION;
				code = {8'h00, trk_ver};
			end else
				cls = scdp_pkg::CLS_CDP;
		end else if (trk_snap == scdp_pkg::SNAP_ZERO)
			cls = scdp_pkg::CLS_WLCCP;
		else begin
			cls = scdp_pkg::CLS_UNK_SNAP;
			code = trk_snap;
		end
		r = '0;
		r.kind = scdp_pkg::KIND_CLASS;
		r.cls = cls;
		r.code = code;
		r.is_last = (cls != scdp_pkg::CLS_CDP);
		due_results.push_back(r);
		if (cls == scdp_pkg::CLS_CDP) begin
			for (f = 0; f < 4; f++) begin
				for (int i = 0; i < fsize[f]; i++) begin
					r = '0;
					r.kind = scdp_pkg::KIND_STRING;
					r.fld = f[1:0];
					r.idx = i[3:0];
					r.val = trk_store[fbase[f] + i];
					r.is_last = (f == int'(scdp_pkg::FLD_PLATFORM) && i == fsize[f] - 1);
					due_results.push_back(r);
				end
			end
		end
		clear_tracker();
	endfunction

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap(bit on);
		int r;
		if (!on)
			return 0;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic void open_frame(logic [15:0] snap, logic [7:0] ver);
		fbytes = {};
		repeat (6)
			fbytes.push_back(8'($urandom));
		fbytes.push_back(snap[15:8]);
		fbytes.push_back(snap[7:0]);
		fbytes.push_back(ver);
		repeat (3)
			fbytes.push_back(8'($urandom));
	endfunction

	function automatic void add_record(logic [15:0] t, logic [15:0] len, int nval);
		fbytes.push_back(t[15:8]);
		fbytes.push_back(t[7:0]);
		fbytes.push_back(len[15:8]);
		fbytes.push_back(len[7:0]);
		repeat (nval)
			fbytes.push_back(8'($urandom));
	endfunction

	function automatic void cut_frame(int n);
		while (fbytes.size() > n)
			void'(fbytes.pop_back());
	endfunction

	// one request; valid is only dropped during a gap before the byte
	task automatic send_byte(logic [7:0] b, logic l);
		int gap;
		gap = pick_gap(gaps_on);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		frame_last <= l;
		do @(posedge clk); while (!in_ready);
		track_frame_byte(b, l);
	endtask

	task automatic send_frame();
		foreach (fbytes[i])
			send_byte(fbytes[i], i == fbytes.size() - 1);
	endtask

	// receiver: random stalls plus an optional long hold-off
	initial begin : sink
		int left;
		left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				left = sink_hold;
				sink_hold = 0;
			end
			if (left > 0) begin
				out_ready <= 1'b0;
				left--;
			end else if (stalls_on && $urandom_range(99) < 20) begin
				out_ready <= 1'b0;
				left = pick_gap(1'b1);
			end else
				out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : monitor
		parse_res_t w;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0)
				report_mismatch("result with none due", {15'd0, item_kind}, 16'd0);
			else begin
				w = due_results.pop_front();
				if (item_kind !== w.kind)
					report_mismatch("item_kind", 16'(item_kind), 16'(w.kind));
				if (frame_class !== w.cls)
					report_mismatch("frame_class", 16'(frame_class), 16'(w.cls));
				if (type_code !== w.code)
					report_mismatch("type_code", type_code, w.code);
				if (field_id !== w.fld)
					report_mismatch("field_id", 16'(field_id), 16'(w.fld));
				if (byte_index !== w.idx)
					report_mismatch("byte_index", 16'(byte_index), 16'(w.idx));
				if (byte_value !== w.val)
					report_mismatch("byte_value", 16'(byte_value), 16'(w.val));
				if (run_last !== w.is_last)
					report_mismatch("run_last", 16'(run_last), 16'(w.is_last));
			end
		end
	end

	task automatic test_short_frames();
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		open_frame(scdp_pkg::SNAP_DISC, scdp_pkg::CDP_V1);
		cut_frame(1);
		send_frame();
		// ends on the snap high byte
		open_frame(scdp_pkg::SNAP_DISC, scdp_pkg::CDP_V1);
		cut_frame(7);
		send_frame();
		// cdp type but no version byte
		open_frame(scdp_pkg::SNAP_DISC, scdp_pkg::CDP_V1);
		cut_frame(8);
		send_frame();
		open_frame(16'h1234, scdp_pkg::CDP_V1);
		cut_frame(8);
		send_frame();
		// v1 with nothing to capture
		open_frame(scdp_pkg::SNAP_DISC, scdp_pkg::CDP_V1);
		cut_frame(9);
		send_frame();
	endtask

	task automatic test_snap_types();
		open_frame(scdp_pkg::SNAP_ZERO, 8'h00);
		send_frame();
		open_frame(16'hffff, scdp_pkg::CDP_V1);
		send_frame();
		open_frame(scdp_pkg::SNAP_DISC, 8'hff);
		send_frame();
		open_frame(scdp_pkg::SNAP_DISC, 8'h00);
		send_frame();
	endtask

	task automatic test_records();
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		open_frame(scdp_pkg::SNAP_DISC, scdp_pkg::CDP_V1);
		add_record(scdp_pkg::TLV_DEVICE, 16'd24, 20);
		add_record(16'h0002, 16'd8, 4);
		add_record(scdp_pkg::TLV_PORT, 16'd7, 3);
		add_record(scdp_pkg::TLV_PLATFORM, scdp_pkg::TLV_HDR, 0);
		add_record(scdp_pkg::TLV_VERSION, 16'd10, 6);
		// second device id replaces the first
		add_record(scdp_pkg::TLV_DEVICE, 16'd9, 5);
		add_record(16'hffff, 16'd5, 1);
		send_frame();
	endtask

	task automatic test_length_stop();
		open_frame(scdp_pkg::SNAP_DISC, scdp_pkg::CDP_V1);
		add_record(scdp_pkg::TLV_DEVICE, 16'd10, 6);
		add_record(scdp_pkg::TLV_PORT, 16'd3, 0);
		add_record(scdp_pkg::TLV_PLATFORM, 16'd8, 4);
		send_frame();
		open_frame(scdp_pkg::SNAP_DISC, scdp_pkg::CDP_V1);
		add_record(scdp_pkg::TLV_VERSION, 16'h0000, 0);
		add_record(scdp_pkg::TLV_VERSION, 16'd8, 4);
		send_frame();
	endtask

	task automatic test_cut_records();
		// device record runs past the frame end
		open_frame(scdp_pkg::SNAP_DISC, scdp_pkg::CDP_V1);
		add_record(scdp_pkg::TLV_VERSION, 16'd8, 4);
		add_record(scdp_pkg::TLV_DEVICE, 16'd40, 7);
		send_frame();
		// frame ends inside a record header
		open_frame(scdp_pkg::SNAP_DISC, scdp_pkg::CDP_V1);
		add_record(scdp_pkg::TLV_PORT, 16'd14, 10);
		fbytes.push_back(scdp_pkg::TLV_PLATFORM[15:8]);
		fbytes.push_back(scdp_pkg::TLV_PLATFORM[7:0]);
		send_frame();
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		sink_hold = 300;
		open_frame(scdp_pkg::SNAP_DISC, scdp_pkg::CDP_V1);
		add_record(scdp_pkg::TLV_PORT, 16'd9, 5);
		send_frame();
		open_frame(scdp_pkg::SNAP_ZERO, 8'h00);
		send_frame();
		// sender pauses until the block has drained
		in_valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	initial begin : main
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		frame_last <= 1'b0;
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		sink_hold = 0;
		clear_tracker();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_frames();
		test_snap_types();
		test_records();
		test_length_stop();
		test_cut_records();
		test_backpressure();

		in_valid <= 1'b0;
		for (int i = 0; i < 20000 && due_results.size() != 0; i++)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (due_results.size() != 0)
			report_mismatch("results never came", 16'(due_results.size()), 16'd0);
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ===== files.f =====
sv/scdp_pkg.sv
sv/scdp_ctrl.sv
sv/scdp_dp.sv
sv/snap_cdp_tlv_parser.sv
tb/sv/tb_top.sv
